### rtl/hnfs_pkg.sv
// shared constants and types for the hdlc nrzi frame serializer
package hnfs_pkg;

   localparam int unsigned DATA_W = 8;
   localparam int unsigned PAT_W  = 35;
   localparam int unsigned CNT_W  = 6;
   localparam int unsigned LEFT_W = 4;
   localparam int unsigned RUN_W  = 3;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;

   // ramp ones, training bits, start flag; bit 0 goes out first
   localparam logic [PAT_W-1:0] PREFIX_PATTERN = {FLAG_BYTE, 24'h555555, 3'b111};
   localparam logic [CNT_W-1:0] PREFIX_BITS    = 6'd35;

   // end flag followed by three ramp-down zeros
   localparam logic [PAT_W-1:0] TAIL_PATTERN = {27'd0, FLAG_BYTE};
   localparam logic [CNT_W-1:0] TAIL_BITS    = 6'd11;

   localparam logic [LEFT_W-1:0] BYTE_BITS   = 4'd8;
   localparam logic [RUN_W-1:0]  STUFF_LIMIT = 3'd5;

   // one line symbol from the sequencer to the encoder
   typedef struct packed {
      logic set_level;
      logic bit_value;
      logic frame_end;
   } sym_type;

endpackage

### rtl/hnfs_sequencer.sv
// bit-serial frame sequencer: prefix, stuffed data bits, end flag and ramp-down
module hnfs_sequencer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [hnfs_pkg::DATA_W-1:0] req_tdata,
   input  logic                        req_tuser,
   input  logic                        req_tlast,
   input  logic                        step,
   output logic                        sym_valid,
   output hnfs_pkg::sym_type           sym
);
   import hnfs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEVEL,
      ST_PREFIX,
      ST_DATA,
      ST_STUFF,
      ST_TAIL
   } state_type;

   state_type          state_ff, state_in;
   logic [DATA_W-1:0]  byte_ff, byte_in;
   logic               last_ff, last_in;
   logic [PAT_W-1:0]   pat_ff, pat_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [LEFT_W-1:0]  left_ff, left_in;
   logic [RUN_W-1:0]   ones_ff, ones_in;
   state_type          done_state;

   assign req_tready = (state_ff == ST_IDLE);
   assign sym_valid  = (state_ff != ST_IDLE);
   assign done_state = last_ff ? ST_TAIL : ST_IDLE;

   always_comb begin
      sym.set_level = (state_ff == ST_LEVEL);
      sym.frame_end = (state_ff == ST_TAIL) && (cnt_ff == 6'd1);
      unique case (state_ff)
         ST_PREFIX, ST_TAIL: sym.bit_value = pat_ff[0];
         ST_DATA:            sym.bit_value = byte_ff[0];
         ST_STUFF:           sym.bit_value = 1'b0;
         default:            sym.bit_value = 1'b1;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      pat_in   = pat_ff;
      cnt_in   = cnt_ff;
      left_in  = left_ff;
      ones_in  = ones_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               byte_in = req_tdata;
               last_in = req_tlast;
               left_in = BYTE_BITS;
               if (req_tuser) begin
                  ones_in  = '0;
                  state_in = ST_LEVEL;
               end else begin
                  state_in = ST_DATA;
               end
            end
         end
         ST_LEVEL: begin
            if (step) begin
               pat_in   = PREFIX_PATTERN;
               cnt_in   = PREFIX_BITS;
               state_in = ST_PREFIX;
            end
         end
         ST_PREFIX: begin
            if (step) begin
               pat_in = pat_ff >> 1;
               cnt_in = cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (step) begin
               byte_in = byte_ff >> 1;
               left_in = left_ff - 4'd1;
               if (byte_ff[0] && (ones_ff == STUFF_LIMIT - 3'd1)) begin
                  ones_in  = '0;
                  state_in = ST_STUFF;
               end else begin
                  ones_in = byte_ff[0] ? ones_ff + 3'd1 : '0;
                  if (left_ff == 4'd1) state_in = done_state;
               end
            end
         end
         ST_STUFF: begin
            if (step) state_in = (left_ff == '0) ? done_state : ST_DATA;
         end
         ST_TAIL: begin
            if (step) begin
               pat_in = pat_ff >> 1;
               cnt_in = cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // entering the tail: load end flag and ramp-down, run count restarts
      if (state_in == ST_TAIL && state_ff != ST_TAIL) begin
         pat_in  = TAIL_PATTERN;
         cnt_in  = TAIL_BITS;
         ones_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ones_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ones_ff  <= ones_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
      pat_ff  <= pat_in;
      cnt_ff  <= cnt_in;
      left_ff <= left_in;
   end

endmodule

### rtl/hnfs_nrzi_encoder.sv
// nrzi line level tracking and the output register of the result channel
module hnfs_nrzi_encoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              sym_valid,
   input  hnfs_pkg::sym_type sym,
   output logic              slot_free,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic              line_bit,
   output logic              frame_end
);
   import hnfs_pkg::*;

   logic level_ff, level_in;
   logic valid_ff, valid_in;
   logic bit_ff, bit_in;
   logic end_ff, end_in;
   logic take;

   assign slot_free = !valid_ff || rsp_tready;
   assign take      = sym_valid && slot_free;

   always_comb begin
      level_in = level_ff;
      valid_in = valid_ff && !rsp_tready;
      bit_in   = bit_ff;
      end_in   = end_ff;
      if (take) begin
         // a zero toggles the line, a one holds it
         if (sym.set_level) level_in = 1'b1;
         else if (!sym.bit_value) level_in = !level_ff;
         valid_in = 1'b1;
         bit_in   = level_in;
         end_in   = sym.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         level_ff <= level_in;
         valid_ff <= valid_in;
      end
      bit_ff <= bit_in;
      end_ff <= end_in;
   end

   assign rsp_tvalid = valid_ff;
   assign line_bit   = bit_ff;
   assign frame_end  = end_ff;

endmodule

### rtl/hdlc_nrzi_frame_serializer_top.sv
// top level of the hdlc nrzi frame serializer
// Takes one frame byte per request and sends its NRZI line bits one per clock
// cycle, while rsp_tready does not hold the output register, through a single
// bit-serial path. A byte without a first mark yields 8 to 10 bits (8 data
// bits plus a stuffed zero after each five ones in a row); a first mark adds
// 36 bits ahead of it (level bit, ramp, training and start flag) and a last
// mark adds 11 after it (end flag and three ramp-down zeros), 56 bits at most.
// The request is taken in idle, then the bit sequencer steps once per emitted
// bit and stalls while the output register is held by rsp_tready low.
// The next request is taken once the current one's final bit has entered the
// output register.
module hdlc_nrzi_frame_serializer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tuser,   // [0] first_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] line_bit, [7:1] zero
   output logic       rsp_tlast    // frame_end
);
   import hnfs_pkg::*;

   logic    sym_valid;
   sym_type sym;
   logic    slot_free;
   logic    line_bit;

   hnfs_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .step       (slot_free),
      .sym_valid  (sym_valid),
      .sym        (sym)
   );

   hnfs_nrzi_encoder u_encoder (
      .clock      (clock),
      .reset      (reset),
      .sym_valid  (sym_valid),
      .sym        (sym),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .line_bit   (line_bit),
      .frame_end  (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, line_bit};

endmodule
